### sv/lgge_pkg.sv
package lgge_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    localparam int OP_W        = 2;
    localparam int COORD_W     = 6;
    localparam int ROW_IDX_W   = 6;
    localparam int ROW_FIELD_W = 64;

    localparam int NBR_W = 4;
    localparam logic [NBR_W-1:0] BIRTH_COUNT = NBR_W'(3);
    localparam logic [NBR_W-1:0] KEEP_COUNT  = NBR_W'(2);

    typedef enum logic [OP_W-1:0] {
        OP_STAMP = 2'd0,
        OP_WRITE = 2'd1,
        OP_STEP  = 2'd2
    } t_op;

    typedef logic [ROW_FIELD_W-1:0] t_row_field;

endpackage

### sv/lgge_cmd_if.sv
interface lgge_cmd_if;

    logic                             valid;
    logic                             ready;
    logic [lgge_pkg::OP_W-1:0]        operation;
    logic [lgge_pkg::COORD_W-1:0]     cell_x;
    logic [lgge_pkg::COORD_W-1:0]     cell_y;
    logic                             cell_value;

    modport source (output valid, output operation, output cell_x, output cell_y,
                    output cell_value, input ready);
    modport sink   (input valid, input operation, input cell_x, input cell_y,
                    input cell_value, output ready);

endinterface

### sv/lgge_res_if.sv
interface lgge_res_if;

    logic                             valid;
    logic                             ready;
    logic [lgge_pkg::ROW_IDX_W-1:0]   row_index;
    logic [lgge_pkg::ROW_FIELD_W-1:0] row_state;
    logic [lgge_pkg::ROW_FIELD_W-1:0] row_births;
    logic [lgge_pkg::ROW_FIELD_W-1:0] row_deaths;
    logic                             last_row;

    modport source (output valid, output row_index, output row_state, output row_births,
                    output row_deaths, output last_row, input ready);
    modport sink   (input valid, input row_index, input row_state, input row_births,
                    input row_deaths, input last_row, output ready);

endinterface

### sv/lgge_grid_mem.sv
module lgge_grid_mem #(
    parameter int DEPTH = lgge_pkg::GRID_HEIGHT_DEF,
    parameter int WIDTH = lgge_pkg::GRID_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_row_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // unwritten rows read as dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### sv/lgge_row_unit.sv
module lgge_row_unit #(
    parameter int WIDTH = lgge_pkg::GRID_WIDTH_DEF
) (
    input  logic [WIDTH-1:0] i_prev,
    input  logic [WIDTH-1:0] i_cur,
    input  logic [WIDTH-1:0] i_next,
    input  logic             i_interior,
    output logic [WIDTH-1:0] o_row
);

    for (genvar c = 0; c < WIDTH; c++) begin : g_col
        if (c == 0 || c == WIDTH - 1) begin : g_edge
            assign o_row[c] = i_cur[c];
        end else begin : g_inner
            logic [lgge_pkg::NBR_W-1:0] cnt;
            logic                       life;
            assign cnt = lgge_pkg::NBR_W'(i_prev[c-1]) + lgge_pkg::NBR_W'(i_prev[c])
                       + lgge_pkg::NBR_W'(i_prev[c+1]) + lgge_pkg::NBR_W'(i_cur[c-1])
                       + lgge_pkg::NBR_W'(i_cur[c+1])  + lgge_pkg::NBR_W'(i_next[c-1])
                       + lgge_pkg::NBR_W'(i_next[c])   + lgge_pkg::NBR_W'(i_next[c+1]);
            assign life = (cnt == lgge_pkg::BIRTH_COUNT)
                        || (i_cur[c] && cnt == lgge_pkg::KEEP_COUNT);
            assign o_row[c] = i_interior ? life : i_cur[c];
        end
    end

endmodule

### sv/life_grid_generation_engine_unit.sv
// Game of Life (B3/S23) grid engine. The grid of GRID_HEIGHT rows by GRID_WIDTH columns
// sits in a one-row-per-entry memory, all cells dead after reset. A stamp transaction
// sets a plus of five cells (clipped at the grid edges) by read-modify-write of up to
// three rows: a row in the grid is read and then written, a row outside it is skipped,
// and the next command is taken once the last row is done. A single-cell write does the
// same for its one row. A step transaction walks the rows top to bottom through one
// shared row unit, one row per cycle while the result side takes each row, keeping the
// old rows above and below in a three-row window, and sends one result per row with its
// new state, birth and death masks; it stalls row by row when the result side holds a
// row back. Border rows and columns are passed unchanged. Column bits at GRID_WIDTH and
// above read as zero. Operation code 3 is dropped.
module life_grid_generation_engine_unit #(
    parameter int GRID_WIDTH  = lgge_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = lgge_pkg::GRID_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lgge_cmd_if.sink       i_cmd,
    lgge_res_if.source     o_res
);

    localparam int RW = $clog2(GRID_HEIGHT);
    localparam int CW = lgge_pkg::COORD_W + 1;
    localparam logic [1:0] K_LAST = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_ROW,
        S_RMW_RD,
        S_RMW_WR
    } t_state;

    t_state                        r_state;
    logic [RW-1:0]                 r_row;
    logic [GRID_WIDTH-1:0]         r_prev;
    logic [GRID_WIDTH-1:0]         r_cur;
    logic [1:0]                    r_k;
    logic [lgge_pkg::OP_W-1:0]     r_op;
    logic [lgge_pkg::COORD_W-1:0]  r_x;
    logic [lgge_pkg::COORD_W-1:0]  r_y;
    logic                          r_v;
    logic                          r_out_valid;
    logic [lgge_pkg::ROW_IDX_W-1:0] r_out_idx;
    lgge_pkg::t_row_field          r_out_state;
    lgge_pkg::t_row_field          r_out_births;
    lgge_pkg::t_row_field          r_out_deaths;
    logic                          r_out_last;

    logic                  cmd_fire;
    logic                  row_go;
    logic                  row_interior;
    logic                  row_last;
    logic [GRID_WIDTH-1:0] new_row;
    logic [GRID_WIDTH-1:0] mem_rd_data;
    logic                  mem_rd_en;
    logic [RW-1:0]         mem_rd_addr;
    logic                  mem_wr_en;
    logic [RW-1:0]         mem_wr_addr;
    logic [GRID_WIDTH-1:0] mem_wr_data;
    logic [CW-1:0]         tgt_row;
    logic                  tgt_in;
    logic [RW:0]           ahead_row;
    logic [GRID_WIDTH-1:0] cell_mask;
    logic                  fill;

    assign cmd_fire     = i_cmd.valid && i_cmd.ready;
    assign row_go       = (r_state == S_ROW) && (!r_out_valid || o_res.ready);
    assign row_last     = (r_row == RW'(GRID_HEIGHT - 1));
    assign row_interior = (r_row != '0) && !row_last;
    assign tgt_row      = CW'(r_y) + CW'(r_k) - CW'(1);
    assign tgt_in       = tgt_row < CW'(GRID_HEIGHT);
    assign ahead_row    = (RW+1)'(r_row) + (RW+1)'(2);
    assign fill         = (r_op == lgge_pkg::OP_STAMP) ? 1'b1 : r_v;

    always_comb begin
        for (int c = 0; c < GRID_WIDTH; c++) begin
            cell_mask[c] = (CW'(c) == CW'(r_x))
                        || ((r_op == lgge_pkg::OP_STAMP) && (r_k == 2'd1)
                            && ((CW'(c) + CW'(1) == CW'(r_x)) || (CW'(c) == CW'(r_x) + CW'(1))));
        end
    end

    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        unique case (r_state)
            S_IDLE: begin
                mem_rd_en = cmd_fire && (i_cmd.operation == lgge_pkg::OP_STEP);
            end
            S_PRE: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = RW'(1);
            end
            S_ROW: begin
                if (row_go) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_row;
                    mem_wr_data = new_row;
                    if (ahead_row < (RW+1)'(GRID_HEIGHT)) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ahead_row[RW-1:0];
                    end
                end
            end
            S_RMW_RD: begin
                mem_rd_en   = tgt_in;
                mem_rd_addr = tgt_row[RW-1:0];
            end
            S_RMW_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = tgt_row[RW-1:0];
                mem_wr_data = (mem_rd_data & ~cell_mask) | (cell_mask & {GRID_WIDTH{fill}});
            end
            default: begin
            end
        endcase
    end

    lgge_grid_mem #(
        .DEPTH (GRID_HEIGHT),
        .WIDTH (GRID_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    lgge_row_unit #(
        .WIDTH (GRID_WIDTH)
    ) u_row (
        .i_prev     (r_prev),
        .i_cur      (r_cur),
        .i_next     (mem_rd_data),
        .i_interior (row_interior),
        .o_row      (new_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready && !row_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cmd_fire) begin
                        r_op <= i_cmd.operation;
                        r_x  <= i_cmd.cell_x;
                        r_y  <= i_cmd.cell_y;
                        r_v  <= i_cmd.cell_value;
                        priority if (i_cmd.operation == lgge_pkg::OP_STEP) begin
                            r_row   <= '0;
                            r_state <= S_PRE;
                        end else if (i_cmd.operation == lgge_pkg::OP_STAMP) begin
                            r_k     <= 2'd0;
                            r_state <= S_RMW_RD;
                        end else if (i_cmd.operation == lgge_pkg::OP_WRITE) begin
                            r_k     <= 2'd1;
                            r_state <= S_RMW_RD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PRE: begin
                    r_prev  <= '0;
                    r_cur   <= mem_rd_data;
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    if (row_go) begin
                        r_out_valid  <= 1'b1;
                        r_out_idx    <= lgge_pkg::ROW_IDX_W'(r_row);
                        r_out_state  <= lgge_pkg::t_row_field'(new_row);
                        r_out_births <= lgge_pkg::t_row_field'(new_row & ~r_cur);
                        r_out_deaths <= lgge_pkg::t_row_field'(r_cur & ~new_row);
                        r_out_last   <= row_last;
                        r_prev       <= r_cur;
                        r_cur        <= mem_rd_data;
                        if (row_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                    end
                end
                S_RMW_RD, S_RMW_WR: begin
                    if (r_state == S_RMW_RD && tgt_in) begin
                        r_state <= S_RMW_WR;
                    end else if (r_k == K_LAST || r_op == lgge_pkg::OP_WRITE) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_RMW_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.row_index  = r_out_idx;
    assign o_res.row_state  = r_out_state;
    assign o_res.row_births = r_out_births;
    assign o_res.row_deaths = r_out_deaths;
    assign o_res.last_row   = r_out_last;

endmodule

### sv/lgge_checker.sv
module lgge_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cmd_valid,
    input logic                              i_cmd_ready,
    input logic [lgge_pkg::OP_W-1:0]         i_cmd_operation,
    input logic                              i_res_valid,
    input logic                              i_res_ready,
    input logic [lgge_pkg::ROW_IDX_W-1:0]    i_res_row_index,
    input logic [lgge_pkg::ROW_FIELD_W-1:0]  i_res_row_state,
    input logic [lgge_pkg::ROW_FIELD_W-1:0]  i_res_row_births,
    input logic [lgge_pkg::ROW_FIELD_W-1:0]  i_res_row_deaths,
    input logic                              i_res_last_row
);

    // a stalled result stays valid with its row index and last flag unchanged
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_row_index)
            && $stable(i_res_last_row))
        else $error("stalled result changed");

    a_masks_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> ((i_res_row_births & i_res_row_deaths) == '0)
            && ((i_res_row_births & ~i_res_row_state) == '0)
            && ((i_res_row_deaths & i_res_row_state) == '0))
        else $error("birth and death masks disagree with row state");

    a_busy_mid_generation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_last_row |-> !i_cmd_ready)
        else $error("command taken in the middle of a generation");

    a_step_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready && i_cmd_operation == lgge_pkg::OP_STEP |=> !i_cmd_ready)
        else $error("command taken right after a step transaction");

endmodule

bind life_grid_generation_engine_unit lgge_checker u_lgge_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cmd_valid      (i_cmd.valid),
    .i_cmd_ready      (i_cmd.ready),
    .i_cmd_operation  (i_cmd.operation),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_row_index  (o_res.row_index),
    .i_res_row_state  (o_res.row_state),
    .i_res_row_births (o_res.row_births),
    .i_res_row_deaths (o_res.row_deaths),
    .i_res_last_row   (o_res.last_row)
);

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int GW = lgge_pkg::GRID_WIDTH_DEF;
    localparam int GH = lgge_pkg::GRID_HEIGHT_DEF;

    localparam logic [lgge_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = GH + 16;
    localparam int DIRECTED_COUNT = 21;

    typedef struct packed {
        logic [lgge_pkg::OP_W-1:0]    op;
        logic [lgge_pkg::COORD_W-1:0] x;
        logic [lgge_pkg::COORD_W-1:0] y;
        logic                         v;
        logic                         empty_step;
    } cmd_entry_t;

    typedef struct {
        logic [lgge_pkg::ROW_IDX_W-1:0] index;
        lgge_pkg::t_row_field           state;
        lgge_pkg::t_row_field           births;
        lgge_pkg::t_row_field           deaths;
        logic                           last;
    } row_result_t;

    // empty_step marks a step on an all-dead grid: every row comes back zero
    localparam cmd_entry_t DIRECTED [DIRECTED_COUNT] = '{
        '{lgge_pkg::OP_STEP,  6'd0,  6'd0,  1'b0, 1'b1},
        '{lgge_pkg::OP_STAMP, 6'd0,  6'd0,  1'b0, 1'b0},
        '{lgge_pkg::OP_STAMP, 6'd63, 6'd63, 1'b0, 1'b0},
        '{lgge_pkg::OP_STAMP, 6'd63, 6'd0,  1'b0, 1'b0},
        '{lgge_pkg::OP_STAMP, 6'd0,  6'd63, 1'b0, 1'b0},
        '{lgge_pkg::OP_STEP,  6'd0,  6'd0,  1'b0, 1'b0},
        '{lgge_pkg::OP_WRITE, 6'd63, 6'd63, 1'b0, 1'b0},
        '{lgge_pkg::OP_WRITE, 6'd0,  6'd0,  1'b0, 1'b0},
        '{OP_UNUSED,          6'd63, 6'd63, 1'b1, 1'b0},
        '{lgge_pkg::OP_STAMP, 6'd20, 6'd20, 1'b0, 1'b0},
        '{lgge_pkg::OP_STEP,  6'd0,  6'd0,  1'b0, 1'b0},
        '{lgge_pkg::OP_WRITE, 6'd30, 6'd30, 1'b1, 1'b0},
        '{lgge_pkg::OP_WRITE, 6'd31, 6'd30, 1'b1, 1'b0},
        '{lgge_pkg::OP_WRITE, 6'd32, 6'd30, 1'b1, 1'b0},
        '{lgge_pkg::OP_STEP,  6'd63, 6'd63, 1'b1, 1'b0},
        '{lgge_pkg::OP_STEP,  6'd0,  6'd0,  1'b0, 1'b0},
        '{lgge_pkg::OP_WRITE, 6'd42, 6'd21, 1'b1, 1'b0},
        '{lgge_pkg::OP_WRITE, 6'd21, 6'd42, 1'b1, 1'b0},
        '{lgge_pkg::OP_WRITE, 6'd31, 6'd30, 1'b0, 1'b0},
        '{lgge_pkg::OP_STAMP, 6'd1,  6'd62, 1'b0, 1'b0},
        '{lgge_pkg::OP_STEP,  6'd0,  6'd0,  1'b0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    lgge_cmd_if cmd_if ();
    lgge_res_if res_if ();

    life_grid_generation_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    lgge_pkg::t_row_field live_grid  [GH];
    lgge_pkg::t_row_field prior_grid [GH];
    row_result_t          pending_rows [$];

    int mismatch_count = 0;
    int rows_taken     = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    bit hold_done      = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(string field, int row, logic [63:0] want, logic [63:0] got);
        $display("mismatch on %s, row %0d: expected %h, got %h", field, row, want, got);
        mismatch_count++;
    endtask

    function automatic void put_cell(int x, int y, logic v);
        if (x >= 0 && y >= 0 && x < GW && y < GH) begin
            live_grid[y][x] = v;
        end
    endfunction

    function automatic void advance_generation(bit keep_rows);
        logic [lgge_pkg::NBR_W-1:0] count;
        logic                       alive;
        lgge_pkg::t_row_field       col_mask;
        row_result_t                row;
        col_mask = (GW >= lgge_pkg::ROW_FIELD_W) ? '1
                 : ((lgge_pkg::t_row_field'(1) << GW) - 1);
        prior_grid = live_grid;
        for (int y = 1; y < GH - 1; y++) begin
            for (int x = 1; x < GW - 1; x++) begin
                count = '0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        if (dx != 0 || dy != 0) begin
                            count += lgge_pkg::NBR_W'(prior_grid[y + dy][x + dx]);
                        end
                    end
                end
                alive = prior_grid[y][x];
                live_grid[y][x] = alive ? (count == lgge_pkg::KEEP_COUNT
                                           || count == lgge_pkg::BIRTH_COUNT)
                                        : (count == lgge_pkg::BIRTH_COUNT);
            end
        end
        if (keep_rows) begin
            for (int r = 0; r < GH; r++) begin
                row.index  = lgge_pkg::ROW_IDX_W'(r);
                row.state  = live_grid[r] & col_mask;
                row.births = live_grid[r] & ~prior_grid[r] & col_mask;
                row.deaths = prior_grid[r] & ~live_grid[r] & col_mask;
                row.last   = (r == GH - 1);
                pending_rows.push_back(row);
            end
        end
    endfunction

    function automatic void apply_command(cmd_entry_t c);
        int x;
        int y;
        x = int'(c.x);
        y = int'(c.y);
        case (c.op)
            lgge_pkg::OP_STAMP: begin
                put_cell(x, y, 1'b1);
                put_cell(x - 1, y, 1'b1);
                put_cell(x + 1, y, 1'b1);
                put_cell(x, y - 1, 1'b1);
                put_cell(x, y + 1, 1'b1);
            end
            lgge_pkg::OP_WRITE: begin
                put_cell(x, y, c.v);
            end
            lgge_pkg::OP_STEP: begin
                if (c.empty_step) begin
                    advance_generation(1'b0);
                    for (int r = 0; r < GH; r++) begin
                        pending_rows.push_back('{lgge_pkg::ROW_IDX_W'(r), '0, '0, '0,
                                                 r == GH - 1});
                    end
                end else begin
                    advance_generation(1'b1);
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_command(cmd_entry_t c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.operation  <= c.op;
        cmd_if.cell_x     <= c.x;
        cmd_if.cell_y     <= c.y;
        cmd_if.cell_value <= c.v;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        burst_left--;
    endtask

    initial begin
        cmd_entry_t c;
        int         counted;
        int         pick;
        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.operation  <= lgge_pkg::OP_STAMP;
        cmd_if.cell_x     <= '0;
        cmd_if.cell_y     <= '0;
        cmd_if.cell_value <= 1'b0;
        for (int r = 0; r < GH; r++) begin
            live_grid[r] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            send_command(DIRECTED[i]);
            apply_command(DIRECTED[i]);
        end

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                c.op = OP_UNUSED;
            end else if (pick < 17) begin
                c.op = lgge_pkg::OP_STEP;
            end else if (pick < 60) begin
                c.op = lgge_pkg::OP_STAMP;
            end else begin
                c.op = lgge_pkg::OP_WRITE;
            end
            // cluster half the coordinates so that patterns meet and interact
            if ($urandom_range(1) == 1) begin
                c.x = lgge_pkg::COORD_W'($urandom_range(63));
                c.y = lgge_pkg::COORD_W'($urandom_range(63));
            end else begin
                c.x = lgge_pkg::COORD_W'($urandom_range(40, 24));
                c.y = lgge_pkg::COORD_W'($urandom_range(40, 24));
            end
            c.v          = 1'($urandom_range(1));
            c.empty_step = 1'b0;
            send_command(c);
            apply_command(c);
            if (c.op != OP_UNUSED) begin
                counted++;
            end
        end
        cmd_if.valid <= 1'b0;

        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        int mode;
        int span;
        int tick;
        tick = 0;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            mode = $urandom_range(2);
            span = $urandom_range(10, 60);
            repeat (span) begin
                @(posedge i_clk);
                tick++;
                if (!hold_done && rows_taken >= HOLD_AFTER) begin
                    hold_done = 1'b1;
                    res_if.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= 1'($urandom_range(1));
                    default: res_if.ready <= (tick % 4) != 3;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        row_result_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            rows_taken++;
            if (pending_rows.size() == 0) begin
                report_mismatch("row with no transaction pending", int'(res_if.row_index),
                                '0, res_if.row_state);
            end else begin
                want = pending_rows.pop_front();
                if (res_if.row_index !== want.index)
                    report_mismatch("row_index", int'(want.index), 64'(want.index),
                                    64'(res_if.row_index));
                if (res_if.row_state !== want.state)
                    report_mismatch("row_state", int'(want.index), want.state,
                                    res_if.row_state);
                if (res_if.row_births !== want.births)
                    report_mismatch("row_births", int'(want.index), want.births,
                                    res_if.row_births);
                if (res_if.row_deaths !== want.deaths)
                    report_mismatch("row_deaths", int'(want.index), want.deaths,
                                    res_if.row_deaths);
                if (res_if.last_row !== want.last)
                    report_mismatch("last_row", int'(want.index), 64'(want.last),
                                    64'(res_if.last_row));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
